>>> hdl/weighted_or_round_robin_picker_top_defines.svh
// Assertion macros for the weighted or round-robin picker.
`ifndef WEIGHTED_OR_ROUND_ROBIN_PICKER_TOP_DEFINES_SVH
`define WEIGHTED_OR_ROUND_ROBIN_PICKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WRRP_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WRRP_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> hdl/wrrp_pkg.sv
// Shared types and constants of the weighted or round-robin picker.
package wrrp_pkg;

   // item operation codes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_PICK   = 2'd2;

   localparam int unsigned SUM_BITS = 24;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] weight;
      logic [23:0] roll;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  entry_index;
      logic [23:0] total_weight;
      logic        table_full;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic start;          // item accepted, perform its table update
      logic walk;           // result comes from the weighted walk
      logic step;           // walk moves on to the next entry
      logic out_load;       // load the output register
      logic out_from_hold;  // output register takes the held result
      logic hold_load;      // park the result until the output frees
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic needs_walk;     // offered item is a weighted pick that walks
      logic walk_done;      // current walk entry ends the search
      logic out_free;       // output register can take a result now
   } status_type;

endpackage

>>> hdl/wrrp_ctrl.sv
// Controller state machine of the picker.
module wrrp_ctrl
   import wrrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (status.needs_walk) begin
                  state_in = ST_WALK;
               end else if (status.out_free) begin
                  cmd.out_load = 1'b1;
               end else begin
                  cmd.hold_load = 1'b1;
                  state_in      = ST_HOLD;
               end
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (!status.walk_done) begin
               cmd.step = 1'b1;
            end else if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.hold_load = 1'b1;
               state_in      = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_from_hold = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/wrrp_dp.sv
// Datapath of the picker: weight memory, totals, walk unit and output register.
module wrrp_dp
   import wrrp_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 256,
   parameter int unsigned WEIGHT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

   logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];

   logic [CW-1:0]          count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic                   order_ff, order_in;
   logic [SUM_BITS-1:0]    roll_ff, roll_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic [WEIGHT_BITS-1:0] rd_data_ff;
   rsp_type                hold_ff, hold_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [WEIGHT_BITS-1:0] wgt;
   logic [SUM_BITS:0]      sum_add;
   logic [IW-1:0]          seq_sel;
   logic [CW-1:0]          seq_inc;
   logic [CW-1:0]          idx_inc;
   logic                   walk_hit;
   logic [IW-1:0]          rd_addr;
   logic                   mem_we;
   logic [IW-1:0]          sel_idx;
   logic [IW+7:0]          sel_wide;
   rsp_type                imm_rsp;
   rsp_type                live_rsp;

   assign wgt     = req_data.weight[WEIGHT_BITS-1:0];
   assign sum_add = {1'b0, sum_ff} + (SUM_BITS + 1)'(wgt);

   // round-robin pointer with stale-pointer fallback to entry 0
   assign seq_sel = (CW'(ptr_ff) >= count_ff) ? '0 : ptr_ff;
   assign seq_inc = CW'(seq_sel) + CW'(1);

   // walk compare against the entry read last cycle
   assign idx_inc  = CW'(idx_ff) + CW'(1);
   assign walk_hit = (roll_ff <= SUM_BITS'(rd_data_ff));

   assign status.needs_walk = (req_data.mode == MODE_PICK) && (count_ff != '0) &&
                              order_ff && (sum_ff != '0);
   assign status.walk_done  = walk_hit || (idx_inc == count_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // result and state update of an item finished at acceptance
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      ptr_in   = ptr_ff;
      mem_we   = 1'b0;
      sel_idx  = '0;
      imm_rsp  = '0;
      unique case (req_data.mode)
         MODE_CLEAR: begin
            count_in = '0;
            sum_in   = '0;
            ptr_in   = '0;
         end
         MODE_APPEND: begin
            if (count_ff >= COUNT_MAX) begin
               imm_rsp.table_full = 1'b1;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               sum_in   = sum_add[SUM_BITS] ? SUM_MAX : sum_add[SUM_BITS-1:0];
            end
         end
         MODE_PICK: begin
            if ((count_ff != '0) && !order_ff) begin
               imm_rsp.found = 1'b1;
               sel_idx       = seq_sel;
               ptr_in        = (seq_inc >= count_ff) ? '0 : seq_inc[IW-1:0];
            end
         end
         default: begin
         end
      endcase
      if (!cmd.start) begin
         count_in = count_ff;
         sum_in   = sum_ff;
         ptr_in   = ptr_ff;
         mem_we   = 1'b0;
      end
      if (cmd.walk) begin
         sel_idx = idx_ff;
      end
      sel_wide = {8'b0, sel_idx};
      imm_rsp.entry_index  = sel_wide[7:0];
      imm_rsp.total_weight = sum_in;
   end

   // result of the current item
   always_comb begin
      live_rsp = imm_rsp;
      if (cmd.walk) begin
         live_rsp              = '0;
         live_rsp.found        = 1'b1;
         live_rsp.entry_index  = sel_wide[7:0];
         live_rsp.total_weight = sum_ff;
      end
   end

   // walk registers and read address
   always_comb begin
      roll_in = roll_ff;
      idx_in  = idx_ff;
      rd_addr = '0;
      if (cmd.start) begin
         roll_in = req_data.roll;
         idx_in  = '0;
      end else if (cmd.step) begin
         roll_in = roll_ff - SUM_BITS'(rd_data_ff);
         idx_in  = idx_inc[IW-1:0];
         rd_addr = idx_inc[IW-1:0];
      end
   end

   // hold and output registers
   always_comb begin
      order_in     = csr_we ? csr_wdata : order_ff;
      hold_in      = cmd.hold_load ? live_rsp : hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_in       = cmd.out_from_hold ? hold_ff : live_rsp;
         rsp_valid_in = 1'b1;
      end
   end

   // weight memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[IW-1:0]] <= wgt;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_ff       <= '0;
         ptr_ff       <= '0;
         order_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ptr_ff       <= ptr_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      roll_ff <= roll_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/weighted_or_round_robin_picker_top.sv
// Top level of the weighted or round-robin picker.
//
//   channel   ports                      direction   payload
//   request   req_valid/req_stall        in          req_type: mode, weight, roll
//   response  rsp_valid/rsp_stall        out         rsp_type: found, entry_index,
//                                                    total_weight, table_full
//   config    csr_we/csr_wdata           in          weighted_order
//
// Clear, append and round-robin pick finish at acceptance; a weighted pick
// then walks the entries, 1 to MAX_ENTRIES of them, one entry per
// cycle through the weight memory's single read port.
// Reset clears counts, total and pointer; the weight memory needs no clearing.
// A new item is taken while an earlier result waits in the output register;
// if that register is still stalled, the new result is parked and intake stops.
module weighted_or_round_robin_picker_top
   import wrrp_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = 256,
   parameter int unsigned WEIGHT_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

`include "weighted_or_round_robin_picker_top_defines.svh"

   cmd_type    cmd;
   status_type status;

   wrrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wrrp_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // checks on controller and datapath cooperation
   `WRRP_ASSERT_NOW(a_load_when_free, clock, reset, cmd.out_load, status.out_free, "output loaded while occupied")
   `WRRP_ASSERT_NOW(a_one_dest, clock, reset, cmd.hold_load, !cmd.out_load, "result sent to hold and output")
   `WRRP_ASSERT_NOW(a_walk_busy, clock, reset, cmd.step, req_stall, "walk step while accepting items")
   `WRRP_ASSERT_NEXT(a_item_tracked, clock, reset, req_valid && !req_stall, rsp_valid || req_stall, "accepted item lost")

endmodule
